### sv/bitmap_page_allocator_top_assert.svh
// Assertion macros shared by the checker of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int IDX_W = 13;
    localparam int CNT_W = 14;

    localparam logic [IDX_W-1:0] START_RESET = 13'd256;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MSETUP,
        S_MARK,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_FREE  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    // Outcome of scanning one byte of the used map.
    typedef struct packed {
        logic             found;
        logic             new_first;
        logic [2:0]       first_off;
        logic [CNT_W-1:0] run;
    } t_scan_res;

endpackage

### sv/bitmap_page_allocator_top.sv
// First-fit page allocator over a used/free bitmap held in a RAM of 32-bit words, one bit per
// page. After reset the block clears the map word by word and accepts no item until that pass
// is done; configuration writes are taken at any time. Each item then runs on its own: an
// allocation reads the map word by word from the word that holds search_start_page, settling a
// word that is all free or all used at once and stepping through a mixed word byte by byte,
// where one shared byte scanner steps eight pages a cycle. A found run, and every mark or free
// range, is then written back by read-modify-write at one word per cycle.
// The result is held in an output register, so a new item can be accepted while it waits.
`timescale 1ns / 1ps

module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: search_start_page.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    // Requests.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // page_index[12:0], page_count[26:13], zero above
    input  logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    // Results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // base_page[12:0], zero above
    output logic [1:0]  o_m_axis_tuser   // status[1:0]
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int WAW = PW - 5;
    localparam int MW  = (NUM_PAGES + 31) / 32;
    localparam int XW  = (PW + 1 > 15) ? PW + 1 : 15;
    localparam int CW  = bpa_pkg::CNT_W;
    localparam int IW  = bpa_pkg::IDX_W;

    localparam logic [WAW-1:0] LAST_WORD = WAW'(MW - 1);
    localparam logic [XW-1:0]  NUM_X     = XW'(NUM_PAGES);
    // Pages past the end of the map in the last word always read as used.
    localparam logic [31:0] TAIL_MASK = (NUM_PAGES % 32 == 0) ? 32'h0 :
                                        ~((32'h1 << (NUM_PAGES % 32)) - 32'h1);

    bpa_pkg::t_state  r_state, n_state;
    logic [IW-1:0]    r_search_start;
    logic [1:0]       r_type, n_type;
    logic [IW-1:0]    r_index, n_index;
    logic [CW-1:0]    r_count, n_count;
    logic [WAW-1:0]   r_word, n_word;
    logic [1:0]       r_byte, n_byte;
    logic [CW-1:0]    r_run, n_run;
    logic [PW-1:0]    r_mfirst, n_mfirst;
    logic [PW-1:0]    r_mlast, n_mlast;
    logic [XW-1:0]    r_mn, n_mn;
    logic [WAW-1:0]   r_mword, n_mword;
    logic             r_mset, n_mset;
    bpa_pkg::t_status r_res_status, n_res_status;
    logic [IW-1:0]    r_res_base, n_res_base;
    logic             r_out_valid, n_out_valid;
    bpa_pkg::t_status r_out_status, n_out_status;
    logic [IW-1:0]    r_out_base, n_out_base;

    logic             ram_wr_en, ram_rd_en;
    logic [WAW-1:0]   ram_wr_addr, ram_rd_addr;
    logic [31:0]      ram_wr_data, ram_rd_data;

    logic [XW-1:0]    start_x, index_x, count_x, end_x, last_x, fast_x, loop_x;
    logic [PW-1:0]    start_pg, word_base, fast_first, loop_first;
    logic [WAW-1:0]   start_word;
    logic [31:0]      scan_word, mark_mask;
    logic [7:0]       scan_byte;
    logic [CW:0]      run_sum;
    logic [4:0]       mark_lo, mark_hi;
    logic             s_accept;
    bpa_pkg::t_scan_res scan_res;

    bpa_ram #(
        .WIDTH(32),
        .DEPTH(MW)
    ) u_map (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    bpa_scan u_scan (
        .i_bits (scan_byte),
        .i_run  (r_run),
        .i_count(r_count),
        .o_res  (scan_res)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == bpa_pkg::S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_base};
    assign o_m_axis_tuser  = r_out_status;

    // Request arithmetic, done at a width that holds index plus count and the page total.
    assign start_x    = XW'(r_search_start);
    assign start_pg   = start_x[PW-1:0];
    assign start_word = start_pg[PW-1:5];
    assign index_x    = XW'(r_index);
    assign count_x    = XW'(r_count);
    assign end_x      = index_x + count_x;
    assign last_x     = XW'(r_mfirst) + r_mn - XW'(1);

    // The word under scan, with pages below the start page and past the end forced used.
    assign scan_word = ram_rd_data
                     | ((r_word == start_word) ? ((32'h1 << start_pg[4:0]) - 32'h1) : 32'h0)
                     | ((r_word == LAST_WORD) ? TAIL_MASK : 32'h0);
    assign scan_byte = scan_word[{r_byte, 3'b000} +: 8];
    assign run_sum   = {1'b0, r_run} + (CW + 1)'(32);

    // A fully free word either completes the run or extends it by 32 pages.
    assign word_base  = {r_word, 5'd0};
    assign fast_first = (r_run == '0) ? word_base : r_mfirst;
    assign loop_first = scan_res.new_first ? {r_word, r_byte, scan_res.first_off} : r_mfirst;
    assign fast_x     = XW'(fast_first);
    assign loop_x     = XW'(loop_first);

    // Bits of the current word that fall inside the range being written.
    assign mark_lo   = (r_mword == r_mfirst[PW-1:5]) ? r_mfirst[4:0] : 5'd0;
    assign mark_hi   = (r_mword == r_mlast[PW-1:5]) ? r_mlast[4:0] : 5'd31;
    assign mark_mask = (32'hFFFF_FFFF << mark_lo) & (32'hFFFF_FFFF >> (5'd31 - mark_hi));

    always_comb begin
        n_state      = r_state;
        n_type       = r_type;
        n_index      = r_index;
        n_count      = r_count;
        n_word       = r_word;
        n_byte       = r_byte;
        n_run        = r_run;
        n_mfirst     = r_mfirst;
        n_mlast      = r_mlast;
        n_mn         = r_mn;
        n_mword      = r_mword;
        n_mset       = r_mset;
        n_res_status = r_res_status;
        n_res_base   = r_res_base;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_base   = r_out_base;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_mword;
        ram_wr_data  = 32'h0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_word;

        case (r_state)
            bpa_pkg::S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (r_mword == LAST_WORD) begin
                    n_state = bpa_pkg::S_IDLE;
                end else begin
                    n_mword = r_mword + 1'b1;
                end
            end

            bpa_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_type  = i_s_axis_tuser;
                    n_index = i_s_axis_tdata[IW-1:0];
                    n_count = i_s_axis_tdata[IW+CW-1:IW];
                    n_state = bpa_pkg::S_DECODE;
                end
            end

            bpa_pkg::S_DECODE: begin
                n_res_base = '0;
                case (r_type)
                    bpa_pkg::REQ_ALLOC: begin
                        if (r_count == '0) begin
                            n_res_status = bpa_pkg::ST_BAD;
                            n_state      = bpa_pkg::S_RESP;
                        end else if (start_x >= NUM_X) begin
                            n_res_status = bpa_pkg::ST_NOFIT;
                            n_state      = bpa_pkg::S_RESP;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = start_word;
                            n_word      = start_word;
                            n_byte      = 2'd0;
                            n_run       = '0;
                            n_state     = bpa_pkg::S_SCAN;
                        end
                    end
                    bpa_pkg::REQ_MARK, bpa_pkg::REQ_FREE: begin
                        n_mset = (r_type == bpa_pkg::REQ_MARK);
                        if (r_count == '0) begin
                            n_res_status = bpa_pkg::ST_OK;
                            n_state      = bpa_pkg::S_RESP;
                        end else if (index_x >= NUM_X) begin
                            n_res_status = bpa_pkg::ST_BAD;
                            n_state      = bpa_pkg::S_RESP;
                        end else begin
                            n_mfirst = index_x[PW-1:0];
                            if (end_x > NUM_X) begin
                                n_mn         = NUM_X - index_x;
                                n_res_status = bpa_pkg::ST_BAD;
                            end else begin
                                n_mn         = count_x;
                                n_res_status = bpa_pkg::ST_OK;
                            end
                            n_state = bpa_pkg::S_MSETUP;
                        end
                    end
                    default: begin
                        n_res_status = bpa_pkg::ST_BAD;
                        n_state      = bpa_pkg::S_RESP;
                    end
                endcase
            end

            bpa_pkg::S_SCAN: begin
                logic adv;
                adv = 1'b0;
                if (r_byte == 2'd0 && (&scan_word)) begin
                    n_run = '0;
                    adv   = 1'b1;
                end else if (r_byte == 2'd0 && scan_word == 32'h0) begin
                    if (run_sum >= {1'b0, r_count}) begin
                        n_mfirst     = fast_first;
                        n_mn         = count_x;
                        n_mset       = 1'b1;
                        n_res_status = bpa_pkg::ST_OK;
                        n_res_base   = fast_x[IW-1:0];
                        n_state      = bpa_pkg::S_MSETUP;
                    end else begin
                        n_mfirst = fast_first;
                        n_run    = run_sum[CW-1:0];
                        adv      = 1'b1;
                    end
                end else begin
                    n_mfirst = loop_first;
                    if (scan_res.found) begin
                        n_mn         = count_x;
                        n_mset       = 1'b1;
                        n_res_status = bpa_pkg::ST_OK;
                        n_res_base   = loop_x[IW-1:0];
                        n_state      = bpa_pkg::S_MSETUP;
                    end else begin
                        n_run  = scan_res.run;
                        n_byte = r_byte + 1'b1;
                        adv    = (r_byte == 2'd3);
                    end
                end
                if (adv) begin
                    n_byte = 2'd0;
                    if (r_word == LAST_WORD) begin
                        n_res_status = bpa_pkg::ST_NOFIT;
                        n_res_base   = '0;
                        n_state      = bpa_pkg::S_RESP;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_word + 1'b1;
                        n_word      = r_word + 1'b1;
                    end
                end
            end

            bpa_pkg::S_MSETUP: begin
                n_mlast     = last_x[PW-1:0];
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_mfirst[PW-1:5];
                n_mword     = r_mfirst[PW-1:5];
                n_state     = bpa_pkg::S_MARK;
            end

            bpa_pkg::S_MARK: begin
                // The next word is read while this one is written back.
                ram_wr_en   = 1'b1;
                ram_wr_data = r_mset ? (ram_rd_data | mark_mask) : (ram_rd_data & ~mark_mask);
                if (r_mword == r_mlast[PW-1:5]) begin
                    n_state = bpa_pkg::S_RESP;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_mword + 1'b1;
                    n_mword     = r_mword + 1'b1;
                end
            end

            bpa_pkg::S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_base   = r_res_base;
                    n_state      = bpa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bpa_pkg::S_CLEAR;
            r_mword        <= '0;
            r_out_valid    <= 1'b0;
            r_search_start <= bpa_pkg::START_RESET;
        end else begin
            r_state     <= n_state;
            r_mword     <= n_mword;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_search_start <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type       <= n_type;
        r_index      <= n_index;
        r_count      <= n_count;
        r_word       <= n_word;
        r_byte       <= n_byte;
        r_run        <= n_run;
        r_mfirst     <= n_mfirst;
        r_mlast      <= n_mlast;
        r_mn         <= n_mn;
        r_mset       <= n_mset;
        r_res_status <= n_res_status;
        r_res_base   <= n_res_base;
        r_out_status <= n_out_status;
        r_out_base   <= n_out_base;
    end

endmodule

### sv/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### sv/bpa_scan.sv
`timescale 1ns / 1ps

// Walks eight pages of the map, carrying the free-run length across them.
module bpa_scan (
    input  logic [7:0]              i_bits,
    input  logic [bpa_pkg::CNT_W-1:0] i_run,
    input  logic [bpa_pkg::CNT_W-1:0] i_count,
    output bpa_pkg::t_scan_res      o_res
);

    always_comb begin
        logic [bpa_pkg::CNT_W-1:0] run;
        logic                      found;
        logic                      nf;
        logic [2:0]                off;
        run   = i_run;
        found = 1'b0;
        nf    = 1'b0;
        off   = 3'd0;
        for (int j = 0; j < 8; j++) begin
            if (!found) begin
                if (i_bits[j]) begin
                    run = '0;
                end else begin
                    if (run == '0) begin
                        nf  = 1'b1;
                        off = 3'(j);
                    end
                    run = bpa_pkg::CNT_W'(run + 1'b1);
                    if (run == i_count) begin
                        found = 1'b1;
                    end
                end
            end
        end
        o_res.found     = found;
        o_res.new_first = nf;
        o_res.first_off = off;
        o_res.run       = run;
    end

endmodule

### sv/bpa_checker.sv
`timescale 1ns / 1ps
`include "bitmap_page_allocator_top_assert.svh"

module bpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // A stalled result keeps its value.
    `BPA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "result changed while stalled")

    // Only a successful allocation carries a base page.
    `BPA_ASSERT_IMP(a_base_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser != bpa_pkg::ST_OK,
        o_m_axis_tdata == 16'h0,
        "nonzero base page on a failed request")

    // An accepted item keeps the block busy for at least the next cycle.
    `BPA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready,
        "input ready right after an accept")

    // A new result is only loaded while the block is busy with an item.
    `BPA_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n,
        $rose(o_m_axis_tvalid),
        !$past(o_s_axis_tready),
        "result appeared without a request in work")

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
